/* design/kwm_pkg.sv */
package kwm_pkg;

  localparam int unsigned NUM_SOURCES_DEF = 8;
  localparam int unsigned KEY_WIDTH_DEF   = 64;
  localparam int unsigned SRC_W           = 3;
  localparam int unsigned FIELD_KEY_W     = 64;
  // widest cell index over the supported range of sources
  localparam int unsigned MAX_IDX_W       = 6;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_PICK    = 2'd2,
    CMD_NOP     = 2'd3
  } kwm_cmd_e;

  typedef struct packed {
    kwm_cmd_e               cmd;
    logic [SRC_W-1:0]       source;
    logic [FIELD_KEY_W-1:0] head_key;
    logic                   present;
  } kwm_in_t;

  typedef struct packed {
    logic [SRC_W-1:0]       picked_source;
    logic [FIELD_KEY_W-1:0] picked_key;
    logic                   empty_res;
  } kwm_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 clear;
    logic                 load;
    logic                 present;
    logic [SRC_W-1:0]     load_src;
    logic                 remove;
    logic [MAX_IDX_W-1:0] remove_src;
  } kwm_ctrl_t;

endpackage

/* design/kwm_cell.sv */
module kwm_cell #(
  parameter int unsigned KEY_WIDTH = kwm_pkg::KEY_WIDTH_DEF,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned IDX       = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kwm_pkg::kwm_ctrl_t    ctrl_i,
  input  logic [KEY_WIDTH-1:0]  load_key_i,
  input  logic                  cand_valid_i,
  input  logic [KEY_WIDTH-1:0]  cand_key_i,
  input  logic [IDX_W-1:0]      cand_src_i,
  output logic                  cand_valid_o,
  output logic [KEY_WIDTH-1:0]  cand_key_o,
  output logic [IDX_W-1:0]      cand_src_o
);

  logic                 valid_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 load_hit;
  logic                 remove_hit;
  logic                 take_own;
  logic                 cand_valid_q;
  logic [KEY_WIDTH-1:0] cand_key_q;
  logic [IDX_W-1:0]     cand_src_q;

  assign load_hit   = ctrl_i.load && (int'(ctrl_i.load_src) == IDX);
  assign remove_hit = ctrl_i.remove && (int'(ctrl_i.remove_src) == IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (load_hit) begin
      valid_q <= ctrl_i.present;
    end else if (remove_hit) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hit && ctrl_i.present) begin
      key_q <= load_key_i;
    end
  end

  // strict compare: lower index upstream wins ties
  assign take_own = valid_q && (!cand_valid_i || (key_q < cand_key_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
    end else begin
      cand_valid_q <= valid_q || cand_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_own) begin
      cand_key_q <= key_q;
      cand_src_q <= IDX_W'(IDX);
    end else begin
      cand_key_q <= cand_key_i;
      cand_src_q <= cand_src_i;
    end
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_key_o   = cand_key_q;
  assign cand_src_o   = cand_src_q;

endmodule

/* design/k_way_merge_min_select_unit.sv */
// k-way merge minimum selector, one cell per stream in a linear chain
// restart and load items do not raise busy_o; busy_o stays low after them
// a pick item holds busy_o high while the running minimum walks the chain
// one cell per cycle, then the result shows for one cycle and leaves the store
// a new item is taken only while busy_o is low, so picks never overlap; results cannot be stalled
// reset: asynchronous active low, clears all valid bits and any pick in flight
module k_way_merge_min_select_unit #(
  parameter int unsigned NUM_SOURCES = kwm_pkg::NUM_SOURCES_DEF,
  parameter int unsigned KEY_WIDTH   = kwm_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  kwm_pkg::kwm_in_t  item_i,
  output logic              done_o,
  output kwm_pkg::kwm_out_t result_o
);

  localparam int unsigned IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SOURCES + 1);

  // chain taps, tap 0 feeds cell 0 with nothing
  logic                 cand_valid [NUM_SOURCES+1];
  logic [KEY_WIDTH-1:0] cand_key   [NUM_SOURCES+1];
  logic [IDX_W-1:0]     cand_src   [NUM_SOURCES+1];

  kwm_pkg::kwm_ctrl_t   ctrl;
  logic                 accept;
  logic                 pending_q, pending_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 found;

  assign accept = start_i && !pending_q;
  assign busy_o = pending_q;

  // result cycle: the wavefront has passed every cell since the load
  assign done_o = pending_q && (cnt_q == '0);
  assign found  = cand_valid[NUM_SOURCES];

  always_comb begin
    ctrl            = '0;
    ctrl.clear      = accept && (item_i.cmd == kwm_pkg::CMD_RESTART);
    ctrl.load       = accept && ((item_i.cmd == kwm_pkg::CMD_LOAD) ||
                                 (item_i.cmd == kwm_pkg::CMD_PICK));
    ctrl.present    = item_i.present;
    ctrl.load_src   = item_i.source;
    // the picked entry leaves at the edge that ends the result cycle
    ctrl.remove     = done_o && found;
    ctrl.remove_src = kwm_pkg::MAX_IDX_W'(cand_src[NUM_SOURCES]);
  end

  always_comb begin
    pending_d = pending_q;
    cnt_d     = cnt_q;
    if (done_o) begin
      pending_d = 1'b0;
    end else if (pending_q) begin
      cnt_d = cnt_q - 1'b1;
    end else if (accept && (item_i.cmd == kwm_pkg::CMD_PICK)) begin
      pending_d = 1'b1;
      cnt_d     = CNT_W'(NUM_SOURCES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
    end
  end

  assign cand_valid[0] = 1'b0;
  assign cand_key[0]   = '0;
  assign cand_src[0]   = '0;

  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_cell
    kwm_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W),
      .IDX       (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_key_i   (item_i.head_key[KEY_WIDTH-1:0]),
      .cand_valid_i (cand_valid[g]),
      .cand_key_i   (cand_key[g]),
      .cand_src_i   (cand_src[g]),
      .cand_valid_o (cand_valid[g+1]),
      .cand_key_o   (cand_key[g+1]),
      .cand_src_o   (cand_src[g+1])
    );
  end

  // empty store gives zero fields with the empty flag
  always_comb begin
    result_o           = '0;
    result_o.empty_res = !found;
    if (found) begin
      result_o.picked_source = kwm_pkg::SRC_W'(cand_src[NUM_SOURCES]);
      result_o.picked_key    = kwm_pkg::FIELD_KEY_W'(cand_key[NUM_SOURCES]);
    end
  end

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a pick");

  a_pick_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.cmd == kwm_pkg::CMD_PICK)) |=> busy_o)
    else $error("pick item did not start the sweep");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("pick did not retire after its result");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (cnt_q <= CNT_W'(NUM_SOURCES)))
    else $error("sweep counter out of range");

  a_nonbusy_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.cmd != kwm_pkg::CMD_PICK)) |=> !busy_o)
    else $error("non-pick item left the unit busy");

endmodule
